[src/bucketed_peak_meter_ballistics_assert.svh]
// Assertion macros for the bar meter checker.
// Used by bpm_checker.sv; expects clk and rst_n in scope.
`ifndef BUCKETED_PEAK_METER_BALLISTICS_ASSERT_SVH
`define BUCKETED_PEAK_METER_BALLISTICS_ASSERT_SVH

// same-cycle implication
`define BPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bpm_pkg.sv]
// Shared types, constants and helper functions of the bar meter.
// No dependencies; imported by every module of the block except bpm_ram.
package bpm_pkg;

    localparam int BARS         = 64;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_FRAMES   = 4096;

    localparam int BAR_W     = $clog2(BARS);
    localparam int BKT_W     = BAR_W + 1;
    localparam int BAR_IDX_W = 6;

    localparam int CH_CFG_W = 4;
    localparam int FPB_W    = 13;
    localparam int GAIN_W   = 16;
    localparam int RATE_W   = 17;
    localparam int LEVEL_W  = 16;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int EFF_CH_W = $clog2(MAX_CHANNELS + 1);
    localparam int CH_CNT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EFF_FR_W = $clog2(MAX_FRAMES + 1);
    localparam int FC_W     = $clog2(MAX_FRAMES);

    localparam int SUM_W       = SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
    localparam int MAG_W       = SUM_W;
    localparam int DIV_STEPS   = MAG_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int PEAK_W      = SAMPLE_W;
    localparam int ACC_W       = EFF_FR_W + BKT_W;
    localparam int TGT_PROD_W  = PEAK_W + GAIN_W;
    localparam int TGT_SHIFT   = 13;
    localparam int LVL_PROD_W  = LEVEL_W + RATE_W;

    localparam int LEVEL_MAX   = 65535;
    localparam int SNAP_LEVEL  = 7;
    localparam int RATE_ONE    = 65536;
    localparam int ROUND_HALF  = 32768;

    localparam int CH_RESET     = 2;
    localparam int FPB_RESET    = 1024;
    localparam int GAIN_RESET   = 18842;
    localparam int ATTACK_RESET = 43691;
    localparam int DECAY_RESET  = 5461;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS = 3'd0,
        CFG_FRAMES   = 3'd1,
        CFG_GAIN     = 3'd2,
        CFG_ATTACK   = 3'd3,
        CFG_DECAY    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } in_req_t;

    typedef struct packed {
        logic [BAR_IDX_W-1:0] bar_index;
        logic [LEVEL_W-1:0]   bar_level;
        logic                 last_bar;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLOSE,
        ST_FLUSH,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR
    } ctrl_state_t;

    typedef struct packed {
        logic take_sample;
        logic div_step;
        logic close_bucket;
        logic merge_frame;
        logic clear_block;
        logic upd_start;
        logic upd_idle;
        logic upd_mul;
        logic upd_write;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_full;
        logic div_done;
        logic close_needed;
        logic bucket_left;
        logic block_end;
        logic bar_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [EFF_CH_W-1:0] eff_channels(input logic [CH_CFG_W-1:0] c);
        logic [EFF_CH_W-1:0] r;
        if (c == '0)
            r = EFF_CH_W'(1);
        else if (int'(c) > MAX_CHANNELS)
            r = EFF_CH_W'(MAX_CHANNELS);
        else
            r = EFF_CH_W'(c);
        return r;
    endfunction

    function automatic logic [EFF_FR_W-1:0] eff_frames(input logic [FPB_W-1:0] f);
        logic [EFF_FR_W-1:0] r;
        if (f == '0)
            r = EFF_FR_W'(1);
        else if (int'(f) > MAX_FRAMES)
            r = EFF_FR_W'(MAX_FRAMES);
        else
            r = EFF_FR_W'(f);
        return r;
    endfunction

endpackage

[src/bpm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

[src/bpm_ctrl.sv]
// Sequencer of the bar meter: frame intake, divide, bucket close, bar walk.
// Depends on bpm_pkg.
module bpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    input  bpm_pkg::dp_status_t status,
    output bpm_pkg::dp_cmd_t    cmd,
    output logic                in_stall
);
    import bpm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op)
                        state_next = ST_UPD_RD;
                    else if (status.frame_full)
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                if (!status.close_needed)
                    state_next = status.block_end ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (!status.bucket_left)
                    state_next = ST_UPD_RD;
            end
            ST_UPD_RD:  state_next = ST_UPD_MUL;
            ST_UPD_MUL: state_next = ST_UPD_WR;
            ST_UPD_WR:
            begin
                if (status.out_free)
                    state_next = status.bar_last ? ST_IDLE : ST_UPD_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_op)
                    begin
                        cmd.upd_start = 1'b1;
                        cmd.upd_idle  = 1'b1;
                    end
                    else
                    begin
                        cmd.take_sample = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CLOSE:
            begin
                if (status.close_needed)
                    cmd.close_bucket = 1'b1;
                else
                    cmd.merge_frame = 1'b1;
            end
            ST_FLUSH:
            begin
                if (status.bucket_left)
                begin
                    cmd.close_bucket = 1'b1;
                end
                else
                begin
                    cmd.clear_block = 1'b1;
                    cmd.upd_start   = 1'b1;
                end
            end
            ST_UPD_RD:  ;
            ST_UPD_MUL: cmd.upd_mul = 1'b1;
            ST_UPD_WR:  cmd.upd_write = status.out_free;
            default:    ;
        endcase
    end

endmodule

[src/bpm_datapath.sv]
// Datapath of the bar meter: config registers, frame sum, serial divider,
// bucket tracking, target and level stores, level update and output register.
// Depends on bpm_pkg and bpm_ram.
module bpm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpm_pkg::dp_cmd_t              cmd,
    output bpm_pkg::dp_status_t           status,
    input  logic signed [bpm_pkg::SAMPLE_W-1:0] sample,
    input  logic                          cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          out_stall,
    output logic                          out_valid,
    output bpm_pkg::out_req_t             out_data
);
    import bpm_pkg::*;

    // configuration
    logic [CH_CFG_W-1:0] ch_cfg_reg,  ch_cfg_next;
    logic [FPB_W-1:0]    fpb_reg,     fpb_next;
    logic [GAIN_W-1:0]   gain_reg,    gain_next;
    logic [RATE_W-1:0]   attack_reg,  attack_next;
    logic [RATE_W-1:0]   decay_reg,   decay_next;

    // block state
    logic [SUM_W-1:0]    sum_reg,     sum_next;
    logic [CH_CNT_W-1:0] ch_cnt_reg,  ch_cnt_next;
    logic [FC_W-1:0]     fc_reg,      fc_next;
    logic [PEAK_W-1:0]   peak_reg,    peak_next;
    logic [BKT_W-1:0]    bkt_reg,     bkt_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;

    // divider
    logic [MAG_W-1:0]     div_q_reg,   div_q_next;
    logic [EFF_CH_W-1:0]  div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // level walk
    logic [BAR_W-1:0]      bar_reg,    bar_next;
    logic                  idle_reg,   idle_next;
    logic [BARS-1:0]       valid_reg,  valid_next;
    logic [LEVEL_W-1:0]    d_reg,      d_next;
    logic [LEVEL_W-1:0]    cur_reg,    cur_next;
    logic                  rising_reg, rising_next;
    logic [LVL_PROD_W-1:0] prod_reg,   prod_next;

    logic     out_valid_reg, out_valid_next;
    out_req_t out_data_reg,  out_data_next;

    logic [EFF_CH_W-1:0]  eff_ch;
    logic [EFF_FR_W-1:0]  eff_fr;
    logic [SUM_W-1:0]     sample_ext;
    logic [SUM_W-1:0]     sum_new;
    logic [MAG_W-1:0]     mag;
    logic [EFF_CH_W-1:0]  ch_cnt_inc;
    logic [EFF_CH_W:0]    div_r;
    logic                 div_ge;
    logic [EFF_FR_W:0]    bkt_end;
    logic [EFF_FR_W-1:0]  fc_inc;
    logic [PEAK_W-1:0]    mono;
    logic [TGT_PROD_W-1:0] tgt_prod;
    logic [TGT_PROD_W-TGT_SHIFT-1:0] tgt_sh;
    logic [LEVEL_W-1:0]   tgt_val;
    logic [LEVEL_W-1:0]   tgt_rdata;
    logic [LEVEL_W-1:0]   lvl_rdata;
    logic [LEVEL_W-1:0]   t_cur;
    logic [LEVEL_W-1:0]   l_cur;
    logic                 rising;
    logic [LEVEL_W-1:0]   diff;
    logic [RATE_W-1:0]    rate_sel;
    logic [RATE_W-1:0]    rate_eff;
    logic [LVL_PROD_W-1:0] prod_rnd;
    logic [RATE_W-1:0]    step_raw;
    logic [LEVEL_W-1:0]   step;
    logic [LEVEL_W-1:0]   lvl_new;
    logic                 out_free;

    assign eff_ch = eff_channels(ch_cfg_reg);
    assign eff_fr = eff_frames(fpb_reg);

    // frame accumulation and magnitude
    assign sample_ext = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign sum_new    = sum_reg + sample_ext;
    assign mag        = sum_new[SUM_W-1] ? (~sum_new + MAG_W'(1)) : sum_new;
    assign ch_cnt_inc = EFF_CH_W'(ch_cnt_reg) + EFF_CH_W'(1);

    // restoring divide, one quotient bit per cycle
    assign div_r  = {div_rem_reg, div_q_reg[MAG_W-1]};
    assign div_ge = div_r >= (EFF_CH_W+1)'(eff_ch);
    assign mono   = div_q_reg[PEAK_W-1:0];

    // bucket b ends at floor(F*(b+1)/BARS); acc holds F*(b+1)
    assign bkt_end = acc_reg[ACC_W-1:BAR_W];
    assign fc_inc  = EFF_FR_W'(fc_reg) + EFF_FR_W'(1);

    // target = sat((peak * gain) >> 13)
    assign tgt_prod = peak_reg * gain_reg;
    assign tgt_sh   = tgt_prod[TGT_PROD_W-1:TGT_SHIFT];
    assign tgt_val  = (tgt_sh > (TGT_PROD_W-TGT_SHIFT)'(LEVEL_MAX)) ?
                      LEVEL_W'(LEVEL_MAX) : tgt_sh[LEVEL_W-1:0];

    // level update, first half: difference and rate product
    assign t_cur    = idle_reg ? '0 : tgt_rdata;
    assign l_cur    = valid_reg[bar_reg] ? lvl_rdata : '0;
    assign rising   = t_cur > l_cur;
    assign diff     = rising ? (t_cur - l_cur) : (l_cur - t_cur);
    assign rate_sel = rising ? attack_reg : decay_reg;
    assign rate_eff = (rate_sel > RATE_W'(RATE_ONE)) ? RATE_W'(RATE_ONE) : rate_sel;

    // second half: rounded step, clamp, snap
    assign prod_rnd = prod_reg + LVL_PROD_W'(ROUND_HALF);
    assign step_raw = prod_rnd[LVL_PROD_W-1:LEVEL_W];
    assign step     = (step_raw > RATE_W'(d_reg)) ? d_reg : step_raw[LEVEL_W-1:0];

    always_comb
    begin
        logic [LEVEL_W-1:0] lv;
        lv = rising_reg ? (cur_reg + step) : (cur_reg - step);
        lvl_new = (lv < LEVEL_W'(SNAP_LEVEL)) ? '0 : lv;
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign status.frame_full   = ch_cnt_inc >= eff_ch;
    assign status.div_done     = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.bucket_left  = bkt_reg < BKT_W'(BARS);
    assign status.close_needed = status.bucket_left && (bkt_end <= (EFF_FR_W+1)'(fc_reg));
    assign status.block_end    = fc_inc >= eff_fr;
    assign status.bar_last     = bar_reg == BAR_W'(BARS - 1);
    assign status.out_free     = out_free;

    always_comb
    begin
        ch_cfg_next = ch_cfg_reg;
        fpb_next    = fpb_reg;
        gain_next   = gain_reg;
        attack_next = attack_reg;
        decay_next  = decay_reg;
        sum_next    = sum_reg;
        ch_cnt_next = ch_cnt_reg;
        fc_next     = fc_reg;
        peak_next   = peak_reg;
        bkt_next    = bkt_reg;
        acc_next    = acc_reg;
        div_q_next   = div_q_reg;
        div_rem_next = div_rem_reg;
        div_cnt_next = div_cnt_reg;

        if (cmd.take_sample)
        begin
            if (status.frame_full)
            begin
                div_q_next   = mag;
                div_rem_next = '0;
                div_cnt_next = '0;
                sum_next     = '0;
                ch_cnt_next  = '0;
            end
            else
            begin
                sum_next    = sum_new;
                ch_cnt_next = ch_cnt_inc[CH_CNT_W-1:0];
            end
        end

        if (cmd.div_step)
        begin
            div_rem_next = div_ge ? EFF_CH_W'(div_r - (EFF_CH_W+1)'(eff_ch))
                                  : div_r[EFF_CH_W-1:0];
            div_q_next   = {div_q_reg[MAG_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.close_bucket)
        begin
            peak_next = '0;
            bkt_next  = bkt_reg + BKT_W'(1);
            acc_next  = acc_reg + ACC_W'(eff_fr);
        end

        if (cmd.merge_frame)
        begin
            if (mono > peak_reg)
                peak_next = mono;
            fc_next = fc_inc[FC_W-1:0];
        end

        if (cmd.clear_block)
        begin
            sum_next    = '0;
            ch_cnt_next = '0;
            fc_next     = '0;
            peak_next   = '0;
            bkt_next    = '0;
            acc_next    = ACC_W'(eff_fr);
        end

        // geometry writes drop the partial block
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNELS:
                begin
                    ch_cfg_next = cfg_data[CH_CFG_W-1:0];
                    sum_next    = '0;
                    ch_cnt_next = '0;
                    fc_next     = '0;
                    peak_next   = '0;
                    bkt_next    = '0;
                    acc_next    = ACC_W'(eff_fr);
                end
                CFG_FRAMES:
                begin
                    fpb_next    = cfg_data[FPB_W-1:0];
                    sum_next    = '0;
                    ch_cnt_next = '0;
                    fc_next     = '0;
                    peak_next   = '0;
                    bkt_next    = '0;
                    acc_next    = ACC_W'(eff_frames(cfg_data[FPB_W-1:0]));
                end
                CFG_GAIN:   gain_next   = cfg_data[GAIN_W-1:0];
                CFG_ATTACK: attack_next = cfg_data[RATE_W-1:0];
                CFG_DECAY:  decay_next  = cfg_data[RATE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        bar_next       = bar_reg;
        idle_next      = idle_reg;
        valid_next     = valid_reg;
        d_next         = d_reg;
        cur_next       = cur_reg;
        rising_next    = rising_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cmd.upd_start)
        begin
            bar_next  = '0;
            idle_next = cmd.upd_idle;
        end

        if (cmd.upd_mul)
        begin
            d_next      = diff;
            cur_next    = l_cur;
            rising_next = rising;
            prod_next   = diff * rate_eff;
        end

        if (cmd.upd_write)
        begin
            valid_next[bar_reg]     = 1'b1;
            bar_next                = bar_reg + BAR_W'(1);
            out_valid_next          = 1'b1;
            out_data_next.bar_index = BAR_IDX_W'(bar_reg);
            out_data_next.bar_level = lvl_new;
            out_data_next.last_bar  = status.bar_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cfg_reg    <= CH_CFG_W'(CH_RESET);
            fpb_reg       <= FPB_W'(FPB_RESET);
            gain_reg      <= GAIN_W'(GAIN_RESET);
            attack_reg    <= RATE_W'(ATTACK_RESET);
            decay_reg     <= RATE_W'(DECAY_RESET);
            sum_reg       <= '0;
            ch_cnt_reg    <= '0;
            fc_reg        <= '0;
            peak_reg      <= '0;
            bkt_reg       <= '0;
            acc_reg       <= ACC_W'(eff_frames(FPB_W'(FPB_RESET)));
            div_cnt_reg   <= '0;
            bar_reg       <= '0;
            idle_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ch_cfg_reg    <= ch_cfg_next;
            fpb_reg       <= fpb_next;
            gain_reg      <= gain_next;
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            sum_reg       <= sum_next;
            ch_cnt_reg    <= ch_cnt_next;
            fc_reg        <= fc_next;
            peak_reg      <= peak_next;
            bkt_reg       <= bkt_next;
            acc_reg       <= acc_next;
            div_cnt_reg   <= div_cnt_next;
            bar_reg       <= bar_next;
            idle_reg      <= idle_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_q_reg    <= div_q_next;
        div_rem_reg  <= div_rem_next;
        d_reg        <= d_next;
        cur_reg      <= cur_next;
        rising_reg   <= rising_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    bpm_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (BARS)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (cmd.close_bucket),
        .waddr (bkt_reg[BAR_W-1:0]),
        .wdata (tgt_val),
        .raddr (bar_reg),
        .rdata (tgt_rdata)
    );

    bpm_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (BARS)
    ) u_lvl_ram (
        .clk   (clk),
        .we    (cmd.upd_write),
        .waddr (bar_reg),
        .wdata (lvl_new),
        .raddr (bar_reg),
        .rdata (lvl_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/bucketed_peak_meter_ballistics.sv]
// Top level of the bucketed peak meter with attack/decay bar ballistics.
// Depends on bpm_pkg, bpm_ctrl, bpm_datapath (and bpm_ram below it).
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one request per channel sample
//   (op = 0) or an idle tick (op = 1). Samples arrive interleaved,
//   channel_count per frame; frames_per_block frames form one block.
//   Output channel (out_valid/out_stall/out_data): after each block end or
//   idle tick, BARS requests, bars 0..BARS-1 in order, last_bar set on the
//   final one.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   write only while the block is quiet. Writing channel_count or
//   frames_per_block drops the partial block, bar levels are kept.
// Sequence:
//   A sample that does not finish a frame only adds to the frame sum. A
//   frame-final sample runs a serial divide by the channel count, then closes
//   due buckets and merges the frame. At block end the remaining buckets close
//   at 1 per cycle, then the bar walk steps each bar through read, multiply
//   and write; the registered RAM read and the rate product register set
//   these steps. An idle tick goes straight to the bar walk.
// Reset clears all counters, bar levels (via per-bar valid bits) and loads
// register defaults; no clearing pass. A stalled receiver holds the walk at
// the current bar; the last result may sit in the output register while new
// input requests are taken.
module bucketed_peak_meter_ballistics (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bpm_pkg::in_req_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bpm_pkg::out_req_t              out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bpm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    // config registers live in flops, no back-pressure needed
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.op),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    bpm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (in_data.sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

[src/bpm_checker.sv]
// Port-level checks of the bar meter, bound to the top level.
// Depends on bpm_pkg and bucketed_peak_meter_ballistics_assert.svh.
`include "bucketed_peak_meter_ballistics_assert.svh"

module bpm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input bpm_pkg::out_req_t out_data
);
    import bpm_pkg::*;

    // stalled result holds
    `BPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // last_bar marks exactly the top bar
    `BPM_ASSERT_SAME(a_last_bar, out_valid, out_data.last_bar == (out_data.bar_index == BAR_IDX_W'(BARS - 1)), "last_bar mismatch")

    // no new input mid walk
    `BPM_ASSERT_NEXT(a_walk_busy, out_valid && !out_stall && !out_data.last_bar, out_valid || in_stall, "input taken during bar walk")

    // snapped levels never fall in the dead zone
    `BPM_ASSERT_SAME(a_snap, out_valid, out_data.bar_level == '0 || out_data.bar_level >= LEVEL_W'(SNAP_LEVEL), "level below snap threshold")

endmodule

bind bucketed_peak_meter_ballistics bpm_checker u_bpm_checker (.*);

[dv/tb_bucketed_peak_meter_ballistics.sv]
// Self-checking testbench for the bucketed peak meter with bar ballistics.
// Depends on bpm_pkg and the RTL under src/; computes the bar levels itself
// and checks every output request against them.
module tb_bucketed_peak_meter_ballistics;

    timeunit 1ns;
    timeprecision 1ps;

    import bpm_pkg::*;

    // ------------------------------------------------------------------
    // Local constants of the level model (independent of the RTL package)
    // ------------------------------------------------------------------
    localparam int NUM_BARS     = 64;
    localparam int CH_LIMIT     = 8;
    localparam int FRAME_LIMIT  = 4096;
    localparam int GAIN_SHIFT   = 13;
    localparam int LVL_FULL     = 65535;
    localparam int LVL_SNAP     = 7;
    localparam int RATE_UNITY   = 65536;
    localparam int STEP_ROUND   = 32768;

    localparam int RST_CHANNELS = 2;
    localparam int RST_FRAMES   = 1024;
    localparam int RST_GAIN     = 18842;
    localparam int RST_ATTACK   = 43691;
    localparam int RST_DECAY    = 5461;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_IDLE   = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;

    // A frame-final sample runs its divide and up to 64 bucket closes without
    // producing any output; SETTLE_CYCLES covers that with margin.
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS  = 200;
    localparam int RANDOM_WALKS  = 10;
    localparam int IDLE_PCT      = 32;
    // Watchdog: ends the run with an error if it has not finished by then.
    localparam longint WATCHDOG_NS = 64'd5_000_000;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        int unsigned          val;
    } reg_write_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_req_t               in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_req_t              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bucketed_peak_meter_ballistics i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Meter state mirror: registers, bar memories and block counters
    // ------------------------------------------------------------------
    logic [CH_CFG_W-1:0] m_channels;
    logic [FPB_W-1:0]    m_frames;
    logic [GAIN_W-1:0]   m_gain;
    logic [RATE_W-1:0]   m_attack;
    logic [RATE_W-1:0]   m_decay;

    logic [LEVEL_W-1:0]  m_target [NUM_BARS];
    logic [LEVEL_W-1:0]  m_level  [NUM_BARS];
    int unsigned         m_frame_cnt;
    int unsigned         m_chan_cnt;
    int                  m_frame_sum;
    int unsigned         m_peak;
    int unsigned         m_bucket;

    out_req_t            levels_due [$];   // bar levels still to come out
    reg_write_t          staged_regs [$];  // register writes for next quiet gap

    int unsigned         walk_count;       // bar walks predicted so far
    int unsigned         items_sent;
    int unsigned         errs;
    bit                  steady;           // suppresses all idling/stalls

    function automatic int unsigned live_channels();
        if (m_channels == '0)
            return 1;
        if (m_channels > CH_LIMIT)
            return CH_LIMIT;
        return m_channels;
    endfunction

    function automatic int unsigned live_frames();
        if (m_frames == '0)
            return 1;
        if (m_frames > FRAME_LIMIT)
            return FRAME_LIMIT;
        return m_frames;
    endfunction

    // First frame index past bucket b: floor(F*(b+1)/BARS)
    function automatic int unsigned bucket_bound(input int unsigned b);
        return (live_frames() * (b + 1)) / NUM_BARS;
    endfunction

    function automatic void clear_block();
        m_frame_cnt = 0;
        m_chan_cnt  = 0;
        m_frame_sum = 0;
        m_peak      = 0;
        m_bucket    = 0;
    endfunction

    function automatic void meter_reset();
        m_channels = CH_CFG_W'(RST_CHANNELS);
        m_frames   = FPB_W'(RST_FRAMES);
        m_gain     = GAIN_W'(RST_GAIN);
        m_attack   = RATE_W'(RST_ATTACK);
        m_decay    = RATE_W'(RST_DECAY);
        for (int b = 0; b < NUM_BARS; b++)
        begin
            m_target[b] = '0;
            m_level[b]  = '0;
        end
        clear_block();
    endfunction

    // Peak * gain (Q3.13) >> 13 gives Q0.16, saturated to full scale
    function automatic void close_one_bucket();
        longint unsigned t;
        if (m_bucket >= NUM_BARS)
            return;
        t = m_peak;
        t = (t * m_gain) >> GAIN_SHIFT;
        if (t > LVL_FULL)
            t = LVL_FULL;
        m_target[m_bucket] = t[LEVEL_W-1:0];
        m_peak   = 0;
        m_bucket = m_bucket + 1;
    endfunction

    // Move every bar toward its target and queue the 64 resulting levels
    function automatic void meter_walk_bars(input bit idle);
        out_req_t        lvl_req;
        longint unsigned tgt;
        longint unsigned lvl;
        longint unsigned rate;
        longint unsigned diff;
        longint unsigned step;
        bit              rising;
        for (int b = 0; b < NUM_BARS; b++)
        begin
            tgt    = idle ? 0 : m_target[b];
            lvl    = m_level[b];
            rising = tgt > lvl;
            rate   = rising ? m_attack : m_decay;
            diff   = rising ? (tgt - lvl) : (lvl - tgt);
            if (rate > RATE_UNITY)
                rate = RATE_UNITY;
            step = (diff * rate + STEP_ROUND) >> 16;
            if (step > diff)
                step = diff;
            lvl = rising ? (lvl + step) : (lvl - step);
            if (lvl < LVL_SNAP)
                lvl = 0;
            if (lvl > LVL_FULL)
                lvl = LVL_FULL;
            m_level[b] = lvl[LEVEL_W-1:0];
            lvl_req.bar_index = BAR_IDX_W'(b);
            lvl_req.bar_level = lvl[LEVEL_W-1:0];
            lvl_req.last_bar  = (b == NUM_BARS - 1);
            levels_due.push_back(lvl_req);
        end
        walk_count++;
    endfunction

    function automatic void meter_apply_item(input in_req_t req);
        int unsigned mag;
        int unsigned mono;
        int unsigned ch;
        if (req.op == OP_IDLE)
        begin
            meter_walk_bars(1'b1);
            return;
        end
        m_frame_sum = m_frame_sum + $signed(req.sample);
        m_chan_cnt  = m_chan_cnt + 1;
        ch = live_channels();
        if (m_chan_cnt < ch)
            return;
        // frame complete: mono = floor(|sum| / channels)
        mag  = (m_frame_sum < 0) ? -m_frame_sum : m_frame_sum;
        mono = mag / ch;
        m_frame_sum = 0;
        m_chan_cnt  = 0;
        while (m_bucket < NUM_BARS && bucket_bound(m_bucket) <= m_frame_cnt)
            close_one_bucket();
        if (mono > m_peak)
            m_peak = mono;
        m_frame_cnt = m_frame_cnt + 1;
        if (m_frame_cnt >= live_frames())
        begin
            while (m_bucket < NUM_BARS)
                close_one_bucket();
            clear_block();
            meter_walk_bars(1'b0);
        end
    endfunction

    function automatic void meter_write_reg(input logic [CFG_IDX_W-1:0] idx,
                                            input int unsigned val);
        case (idx)
            CFG_CHANNELS:
            begin
                m_channels = val[CH_CFG_W-1:0];
                clear_block();
            end
            CFG_FRAMES:
            begin
                m_frames = val[FPB_W-1:0];
                clear_block();
            end
            CFG_GAIN:   m_gain   = val[GAIN_W-1:0];
            CFG_ATTACK: m_attack = val[RATE_W-1:0];
            CFG_DECAY:  m_decay  = val[RATE_W-1:0];
            default: ;  // unmapped index, no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Mix of full-range, extreme and small values; small ones reach the snap
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        int          mag;
        sel = $urandom_range(99);
        if (sel < 40)
            return SAMPLE_W'($urandom);
        if (sel < 60)
        begin
            case ($urandom_range(3))
                0:       return S_MIN;
                1:       return S_MAX;
                2:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        mag = $urandom_range(600);
        return $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    function automatic void note_error(input string msg);
        errs++;
        if (errs <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic void stage_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input int unsigned val);
        reg_write_t w;
        w.idx = idx;
        w.val = val;
        staged_regs.push_back(w);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drain: drop in_valid, wait for every queued bar level, then let a
    // possible non-reporting frame finish inside the block.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes only go out once the block is quiet. cfg_valid is
    // kept high across back-to-back writes and dropped right after the last.
    task automatic commit_regs();
        reg_write_t w;
        wait_quiet();
        while (staged_regs.size() != 0)
        begin
            w = staged_regs.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.val[CFG_DATA_W-1:0];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            meter_write_reg(w.idx, w.val);
        end
        cfg_valid <= 1'b0;
    endtask

    // One input request. in_valid stays high into the next call unless a
    // random gap lowers it, so only one assignment lands per time step.
    task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] value);
        in_req_t req;
        req.op     = op;
        req.sample = value;
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
        meter_apply_item(req);
        items_sent++;
    endtask

    // count random samples, with idle ticks sprinkled in at idle_pct
    task automatic send_block(input int unsigned count, input int unsigned idle_pct);
        for (int unsigned k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < idle_pct)
                send_item(OP_IDLE, pick_sample());
            send_item(OP_SAMPLE, pick_sample());
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= take_break();

    // ------------------------------------------------------------------
    // Output checker: each accepted bar level against the oldest one due
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_req_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (levels_due.size() == 0)
            begin
                note_error($sformatf("unexpected bar idx %0d level %0d last %0b",
                                     out_data.bar_index, out_data.bar_level,
                                     out_data.last_bar));
            end
            else
            begin
                want = levels_due.pop_front();
                if (out_data.bar_index !== want.bar_index
                    || out_data.bar_level !== want.bar_level
                    || out_data.last_bar !== want.last_bar)
                    note_error($sformatf(
                        "exp idx %0d level %0d last %0b, got idx %0d level %0d last %0b",
                        want.bar_index, want.bar_level, want.last_bar,
                        out_data.bar_index, out_data.bar_level, out_data.last_bar));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle tick right after reset: all 64 levels must read zero.
    task automatic test_reset_levels();
        send_item(OP_IDLE, pick_sample());
    endtask

    // Field extremes, saturation, rate extremes, snap to zero, register
    // clamping, floor division and empty buckets, unmapped register indexes.
    task automatic test_directed_edges();
        // one frame per block: every sample updates, only bar 63 has a frame
        stage_reg(CFG_CHANNELS, 1);
        stage_reg(CFG_FRAMES, 1);
        stage_reg(CFG_GAIN, 65535);
        stage_reg(CFG_ATTACK, 131071);     // above one, acts as one
        stage_reg(CFG_DECAY, 0);
        commit_regs();
        send_item(OP_SAMPLE, S_MIN);       // 32768 * max gain saturates
        send_item(OP_SAMPLE, S_MAX);
        send_item(OP_SAMPLE, 16'sd0);      // zero decay holds the level

        stage_reg(CFG_DECAY, RATE_UNITY);
        commit_regs();
        send_item(OP_IDLE, S_MAX);         // full decay to zero

        // small level decays by halves until it snaps to zero
        stage_reg(CFG_GAIN, 16384);
        stage_reg(CFG_ATTACK, RATE_UNITY);
        stage_reg(CFG_DECAY, 32768);
        commit_regs();
        send_item(OP_SAMPLE, 16'sd20);
        send_item(OP_IDLE, S_MIN);
        send_item(OP_IDLE, 16'sd0);
        send_item(OP_IDLE, S_MAX);

        // zero channels and zero frames both act as one; zero gain
        stage_reg(CFG_CHANNELS, 0);
        stage_reg(CFG_FRAMES, 0);
        stage_reg(CFG_GAIN, 0);
        commit_regs();
        send_item(OP_SAMPLE, S_MIN);

        // channel count above the maximum acts as 8; largest frame sum
        stage_reg(CFG_CHANNELS, 15);
        stage_reg(CFG_GAIN, 65535);
        stage_reg(CFG_ATTACK, RST_ATTACK);
        commit_regs();
        repeat (8) send_item(OP_SAMPLE, S_MIN);

        // 3 frames in 64 buckets: most buckets are empty; odd sums floor
        stage_reg(CFG_CHANNELS, 2);
        stage_reg(CFG_FRAMES, 3);
        stage_reg(CFG_GAIN, 16384);
        stage_reg(CFG_DECAY, RST_DECAY);
        for (int k = int'(CFG_DECAY) + 1; k < (1 << CFG_IDX_W); k++)
            stage_reg(CFG_IDX_W'(k), $urandom);
        commit_regs();
        send_item(OP_SAMPLE, -16'sd3);
        send_item(OP_SAMPLE, 16'sd0);
        send_item(OP_SAMPLE, S_MAX);
        send_item(OP_SAMPLE, S_MAX);
        send_item(OP_SAMPLE, S_MIN);
        send_item(OP_SAMPLE, S_MAX);
    endtask

    // Idle ticks inside a block, gain change mid-block, and a geometry
    // write that drops a half-received block.
    task automatic test_partial_blocks();
        stage_reg(CFG_CHANNELS, 3);
        stage_reg(CFG_FRAMES, 5);
        stage_reg(CFG_GAIN, $urandom_range(65535));
        commit_regs();
        send_block(7, 0);                  // two frames and one sample
        send_item(OP_IDLE, pick_sample()); // block carries on afterwards
        send_block(5, 0);
        stage_reg(CFG_GAIN, $urandom_range(65535));
        commit_regs();
        send_block(3, 0);                  // completes the block
        send_block(8, 0);
        stage_reg(CFG_CHANNELS, 3);        // same value, still drops the block
        commit_regs();
        send_block(15, 0);
        send_block(4, 0);
        stage_reg(CFG_FRAMES, 2);
        commit_regs();
        send_block(6, 0);
    endtask

    // Bucket bounds around the bar count at a single channel, each block sent
    // with no input gaps and no receiver stalls.
    task automatic test_block_sizes();
        int unsigned sizes [3];
        sizes = '{63, 64, 65};
        steady = 1'b1;
        foreach (sizes[k])
        begin
            stage_reg(CFG_CHANNELS, 1);
            stage_reg(CFG_FRAMES, sizes[k]);
            stage_reg(CFG_GAIN, $urandom_range(65535));
            commit_regs();
            send_block(sizes[k], 0);
        end
        steady = 1'b0;
    endtask

    // Phases of random settings; mostly whole blocks with random content,
    // some cut short (the next geometry write drops them), idle ticks mixed in.
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned item_mark;
        int unsigned walk_mark;
        int unsigned sel;
        int unsigned per_block;
        phase     = 0;
        item_mark = items_sent;
        walk_mark = walk_count;
        while (items_sent - item_mark < RANDOM_ITEMS || walk_count - walk_mark < RANDOM_WALKS)
        begin
            if (phase == 0 || $urandom_range(99) < 75)
                stage_reg(CFG_CHANNELS, $urandom_range(1) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 15));
            if (phase == 0 || $urandom_range(99) < 75)
            begin
                sel = $urandom_range(99);
                stage_reg(CFG_FRAMES, (sel < 55) ? $urandom_range(0, 8) :
                                      (sel < 85) ? $urandom_range(9, 70) :
                                                   $urandom_range(71, 140));
            end
            if ($urandom_range(99) < 75)
                stage_reg(CFG_GAIN, ($urandom_range(99) < 20) ? 65535 * $urandom_range(1)
                                                             : $urandom_range(65535));
            for (int r = 0; r < 2; r++)
            begin
                if ($urandom_range(99) < 75)
                begin
                    sel = $urandom_range(99);
                    stage_reg(r == 0 ? CFG_ATTACK : CFG_DECAY,
                              (sel < 15) ? 0 :
                              (sel < 30) ? RATE_UNITY :
                              (sel < 40) ? $urandom_range(RATE_UNITY + 1, 131071) :
                                           $urandom_range(1, RATE_UNITY - 1));
                end
            end
            if ($urandom_range(99) < 10)
                stage_reg(CFG_IDX_W'($urandom_range(int'(CFG_DECAY) + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          $urandom);
            commit_regs();
            repeat ($urandom_range(1, 3))
            begin
                if (items_sent - item_mark >= RANDOM_ITEMS
                    && walk_count - walk_mark >= RANDOM_WALKS)
                    break;
                per_block = live_frames() * live_channels();
                if ($urandom_range(99) < 12)
                    send_block($urandom_range(per_block - 1), 5);
                else
                    send_block(per_block, 5);
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        steady     = 1'b0;
        errs       = 0;
        items_sent = 0;
        walk_count = 0;
        meter_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_levels();
        test_directed_edges();
        test_partial_blocks();
        test_block_sizes();
        test_random_traffic();

        // everything sent: drain outstanding levels plus a latency tail
        wait_quiet();
        if (errs == 0 && levels_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/bpm_pkg.sv
src/bpm_ram.sv
src/bpm_ctrl.sv
src/bpm_datapath.sv
src/bucketed_peak_meter_ballistics.sv
src/bpm_checker.sv
dv/tb_bucketed_peak_meter_ballistics.sv
